/* design/glzw_pkg.sv */
// Shared types and constants of the GIF LZW decoder.
// No dependencies; every other design file except glzw_ram refers to this package by scoped names.
package glzw_pkg;

   localparam int BUFFER_BITS = 24;
   localparam int BYTE_BITS   = 8;
   localparam int MIN_SIZE_LO = 2;
   localparam int MIN_SIZE_HI = 8;

   localparam logic [1:0] CSR_MIN_CODE_SIZE = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH   = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT  = 2'd2;
   localparam logic [1:0] CSR_INTERLACED    = 2'd3;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_PUSH  = 2'd1,
      CMD_END   = 2'd2,
      CMD_PULL  = 2'd3
   } req_cmd_type;

   typedef enum logic [2:0] {
      ST_RUNNING   = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_TRUNCATED = 3'd2,
      ST_EARLY_END = 3'd3,
      ST_BAD_CODE  = 3'd4
   } frame_status_type;

   typedef enum logic [2:0] {
      CLS_CLEAR,
      CLS_EOI,
      CLS_KNOWN,
      CLS_KWK,
      CLS_BAD
   } code_class_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_SIMPLE,
      OP_DECODE,
      OP_PUSH_LIT,
      OP_WALK_PUSH,
      OP_ADD,
      OP_POP_RD,
      OP_POP_DATA,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CMD,
      S_DEC,
      S_WALK,
      S_WALK_DATA,
      S_ADD,
      S_POP,
      S_POP_DATA,
      S_EMIT
   } state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic           dec_go;
      code_class_type code_class;
      logic           w_literal;
      logic           pop_ok;
      logic           slot_free;
   } dp_status_type;

   // Interlace pass row starts and row steps.
   function automatic logic [3:0] pass_start(input logic [1:0] pass);
      logic [3:0] r;
      unique case (pass)
         2'd0: r = 4'd0;
         2'd1: r = 4'd4;
         2'd2: r = 4'd2;
         2'd3: r = 4'd1;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] pass_step(input logic [1:0] pass);
      logic [3:0] r;
      unique case (pass)
         2'd0: r = 4'd8;
         2'd1: r = 4'd8;
         2'd2: r = 4'd4;
         2'd3: r = 4'd2;
         default: r = 4'd8;
      endcase
      return r;
   endfunction

endpackage

/* design/glzw_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module glzw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/glzw_datapath.sv */
// Datapath of the GIF LZW decoder: registers, bit buffer, code tables, stack, output register.
// Depends on glzw_pkg and glzw_ram.
module glzw_datapath #(
   parameter int MAX_CODE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_write_data,
   input  logic [1:0]             req_command,
   input  logic [7:0]             req_data_byte,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_pixel_valid,
   output logic [7:0]             rsp_pixel_index,
   output logic [15:0]            rsp_pixel_row,
   output logic [15:0]            rsp_pixel_column,
   output logic                   rsp_need_byte,
   output logic                   rsp_byte_rejected,
   output logic                   rsp_frame_done,
   output logic [2:0]             rsp_frame_status,
   output logic                   rsp_size_clamped,
   input  glzw_pkg::dp_cmd_type   cmd,
   output glzw_pkg::dp_status_type status
);

   localparam int CODE_W = MAX_CODE_BITS;
   localparam int NF_W   = MAX_CODE_BITS + 1;
   localparam int CW_W   = $clog2(MAX_CODE_BITS + 1);
   localparam int DEPTH  = 1 << MAX_CODE_BITS;
   localparam int BUF_W  = glzw_pkg::BUFFER_BITS;
   localparam int CNT_W  = $clog2(glzw_pkg::BUFFER_BITS + 1);

   // Configuration registers.
   logic [3:0]  cfg_min_ff, cfg_min_in;
   logic [15:0] cfg_width_ff, cfg_width_in;
   logic [15:0] cfg_height_ff, cfg_height_in;
   logic        cfg_inter_ff, cfg_inter_in;

   // Frame state.
   logic [3:0]  run_min_ff, run_min_in;
   logic [15:0] run_width_ff, run_width_in;
   logic [15:0] run_height_ff, run_height_in;
   logic        run_inter_ff, run_inter_in;
   logic        clamped_ff, clamped_in;
   logic [NF_W-1:0]   count_ff, count_in;
   logic [NF_W-1:0]   nf_ff, nf_in;
   logic [CW_W-1:0]   cw_ff, cw_in;
   logic [CODE_W-1:0] prev_ff, prev_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [BUF_W-1:0]  buf_ff, buf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [1:0]  pass_ff, pass_in;
   glzw_pkg::frame_status_type status_ff, status_in;
   logic        ended_ff, ended_in;

   // Walk and request working registers.
   logic [CODE_W-1:0] w_ff, w_in;
   logic              kwk_ff, kwk_in;
   logic [7:0]        first_ff, first_in;
   logic [CODE_W-1:0] code_ff, code_in;
   glzw_pkg::req_cmd_type cmd_ff, cmd_in;
   logic [7:0]  byte_ff, byte_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_index_ff, pend_index_in;
   logic [15:0] pend_row_ff, pend_row_in;
   logic [15:0] pend_col_ff, pend_col_in;
   logic        pend_rej_ff, pend_rej_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        o_pvalid_ff, o_pvalid_in;
   logic [7:0]  o_index_ff, o_index_in;
   logic [15:0] o_row_ff, o_row_in;
   logic [15:0] o_col_ff, o_col_in;
   logic        o_need_ff, o_need_in;
   logic        o_rej_ff, o_rej_in;
   logic        o_done_ff, o_done_in;
   logic [2:0]  o_status_ff, o_status_in;
   logic        o_clamped_ff, o_clamped_in;

   // Memories.
   logic              tbl_we;
   logic [CODE_W-1:0] prefix_rd;
   logic [7:0]        suffix_rd;
   logic              stk_we;
   logic [CODE_W-1:0] stk_waddr, stk_raddr;
   logic [7:0]        stk_wdata, stk_rd;

   glzw_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_prefix (
      .clock(clock), .wr_en(tbl_we), .wr_addr(nf_ff[CODE_W-1:0]), .wr_data(prev_ff),
      .rd_addr(w_ff), .rd_data(prefix_rd)
   );

   glzw_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_suffix (
      .clock(clock), .wr_en(tbl_we), .wr_addr(nf_ff[CODE_W-1:0]), .wr_data(first_ff),
      .rd_addr(w_ff), .rd_data(suffix_rd)
   );

   glzw_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rd)
   );

   // Code extraction and classification.
   logic [NF_W-1:0]   clear_code, eoi_code;
   logic [CODE_W-1:0] code_mask, code_now;
   logic [NF_W-1:0]   code_ext;
   logic [CNT_W-1:0]  cw_cnt;
   logic              bits_short;
   glzw_pkg::code_class_type code_class;

   always_comb begin
      clear_code = NF_W'(1) << run_min_ff;
      eoi_code   = clear_code + NF_W'(1);
      for (int i = 0; i < CODE_W; i++) begin
         code_mask[i] = (CW_W'(i) < cw_ff);
      end
      code_now   = buf_ff[CODE_W-1:0] & code_mask;
      code_ext   = {1'b0, code_now};
      cw_cnt     = CNT_W'(cw_ff);
      bits_short = (cnt_ff < cw_cnt);
      priority if (code_ext == clear_code) begin
         code_class = glzw_pkg::CLS_CLEAR;
      end else if (code_ext == eoi_code) begin
         code_class = glzw_pkg::CLS_EOI;
      end else if (code_ext < nf_ff) begin
         code_class = glzw_pkg::CLS_KNOWN;
      end else if (code_ext == nf_ff && prev_valid_ff) begin
         code_class = glzw_pkg::CLS_KWK;
      end else begin
         code_class = glzw_pkg::CLS_BAD;
      end
   end

   logic slot_free;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status.dec_go     = (status_ff == glzw_pkg::ST_RUNNING) && (count_ff == '0) && !bits_short;
      status.code_class = code_class;
      status.w_literal  = ({1'b0, w_ff} < clear_code);
      status.pop_ok     = (status_ff == glzw_pkg::ST_RUNNING) && (count_ff != '0);
      status.slot_free  = slot_free;
   end

   // Frame start values.
   logic [3:0] start_min;
   logic       start_clamped;
   always_comb begin
      start_clamped = (cfg_min_ff < 4'(glzw_pkg::MIN_SIZE_LO)) ||
                      (cfg_min_ff > 4'(glzw_pkg::MIN_SIZE_HI));
      priority if (cfg_min_ff < 4'(glzw_pkg::MIN_SIZE_LO)) begin
         start_min = 4'(glzw_pkg::MIN_SIZE_LO);
      end else if (cfg_min_ff > 4'(glzw_pkg::MIN_SIZE_HI)) begin
         start_min = 4'(glzw_pkg::MIN_SIZE_HI);
      end else begin
         start_min = cfg_min_ff;
      end
   end

   // Position advance after a pixel.
   logic [16:0] col_next, row_next;
   logic [1:0]  pass_next;
   logic        col_wrap;
   always_comb begin
      col_next  = {1'b0, col_ff} + 17'd1;
      col_wrap  = !(col_next < {1'b0, run_width_ff});
      pass_next = pass_ff;
      if (!run_inter_ff) begin
         row_next = {1'b0, row_ff} + 17'd1;
      end else begin
         row_next = {1'b0, row_ff} + 17'(glzw_pkg::pass_step(pass_ff));
         for (int i = 0; i < 3; i++) begin
            if (!(row_next < {1'b0, run_height_ff}) && pass_next != 2'd3) begin
               pass_next = pass_next + 2'd1;
               row_next  = 17'(glzw_pkg::pass_start(pass_next));
            end
         end
      end
   end

   logic [NF_W-1:0] nf_inc;
   logic [NF_W-1:0] cw_limit;
   logic            stack_full;
   logic [7:0]      push_val;
   glzw_pkg::frame_status_type status_fin;

   always_comb begin
      nf_inc     = nf_ff + NF_W'(1);
      cw_limit   = NF_W'(1) << cw_ff;
      stack_full = count_ff[NF_W-1];
      push_val   = (cmd.op == glzw_pkg::OP_WALK_PUSH) ? suffix_rd : w_ff[7:0];
      status_fin = status_ff;
      if (status_ff == glzw_pkg::ST_RUNNING && ended_ff && count_ff == '0 && bits_short) begin
         status_fin = glzw_pkg::ST_TRUNCATED;
      end
   end

   always_comb begin
      tbl_we    = 1'b0;
      stk_we    = 1'b0;
      stk_waddr = count_ff[CODE_W-1:0];
      stk_wdata = push_val;
      stk_raddr = CODE_W'(count_ff - NF_W'(1));

      cfg_min_in    = cfg_min_ff;
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      cfg_inter_in  = cfg_inter_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            glzw_pkg::CSR_MIN_CODE_SIZE: cfg_min_in    = csr_write_data[3:0];
            glzw_pkg::CSR_FRAME_WIDTH:   cfg_width_in  = csr_write_data;
            glzw_pkg::CSR_FRAME_HEIGHT:  cfg_height_in = csr_write_data;
            glzw_pkg::CSR_INTERLACED:    cfg_inter_in  = csr_write_data[0];
            default: ;
         endcase
      end

      run_min_in    = run_min_ff;
      run_width_in  = run_width_ff;
      run_height_in = run_height_ff;
      run_inter_in  = run_inter_ff;
      clamped_in    = clamped_ff;
      count_in      = count_ff;
      nf_in         = nf_ff;
      cw_in         = cw_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      buf_in        = buf_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      pass_in       = pass_ff;
      status_in     = status_ff;
      ended_in      = ended_ff;
      w_in          = w_ff;
      kwk_in        = kwk_ff;
      first_in      = first_ff;
      code_in       = code_ff;
      cmd_in        = cmd_ff;
      byte_in       = byte_ff;
      pend_valid_in = pend_valid_ff;
      pend_index_in = pend_index_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      pend_rej_in   = pend_rej_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      o_pvalid_in   = o_pvalid_ff;
      o_index_in    = o_index_ff;
      o_row_in      = o_row_ff;
      o_col_in      = o_col_ff;
      o_need_in     = o_need_ff;
      o_rej_in      = o_rej_ff;
      o_done_in     = o_done_ff;
      o_status_in   = o_status_ff;
      o_clamped_in  = o_clamped_ff;

      unique case (cmd.op)
         glzw_pkg::OP_ACCEPT: begin
            cmd_in        = glzw_pkg::req_cmd_type'(req_command);
            byte_in       = req_data_byte;
            pend_valid_in = 1'b0;
            pend_index_in = '0;
            pend_row_in   = '0;
            pend_col_in   = '0;
            pend_rej_in   = 1'b0;
         end
         glzw_pkg::OP_SIMPLE: begin
            unique case (cmd_ff)
               glzw_pkg::CMD_START: begin
                  run_min_in    = start_min;
                  clamped_in    = start_clamped;
                  run_width_in  = cfg_width_ff;
                  run_height_in = cfg_height_ff;
                  run_inter_in  = cfg_inter_ff;
                  count_in      = '0;
                  nf_in         = (NF_W'(1) << start_min) + NF_W'(2);
                  cw_in         = CW_W'(start_min) + CW_W'(1);
                  prev_in       = '0;
                  prev_valid_in = 1'b0;
                  buf_in        = '0;
                  cnt_in        = '0;
                  row_in        = '0;
                  col_in        = '0;
                  pass_in       = '0;
                  ended_in      = 1'b0;
                  status_in     = (cfg_width_ff == '0 || cfg_height_ff == '0) ?
                                  glzw_pkg::ST_COMPLETE : glzw_pkg::ST_RUNNING;
               end
               glzw_pkg::CMD_PUSH: begin
                  if (status_ff == glzw_pkg::ST_RUNNING && !ended_ff) begin
                     if (cnt_ff > CNT_W'(glzw_pkg::BUFFER_BITS - glzw_pkg::BYTE_BITS)) begin
                        pend_rej_in = 1'b1;
                     end else begin
                        buf_in = buf_ff | (BUF_W'(byte_ff) << cnt_ff);
                        cnt_in = cnt_ff + CNT_W'(glzw_pkg::BYTE_BITS);
                     end
                  end
               end
               glzw_pkg::CMD_END: begin
                  ended_in = 1'b1;
               end
               glzw_pkg::CMD_PULL: ;
               default: ;
            endcase
         end
         glzw_pkg::OP_DECODE: begin
            buf_in = buf_ff >> cw_ff;
            cnt_in = cnt_ff - cw_cnt;
            unique case (code_class)
               glzw_pkg::CLS_CLEAR: begin
                  nf_in         = eoi_code + NF_W'(1);
                  cw_in         = CW_W'(run_min_ff) + CW_W'(1);
                  prev_valid_in = 1'b0;
               end
               glzw_pkg::CLS_EOI: status_in = glzw_pkg::ST_EARLY_END;
               glzw_pkg::CLS_KNOWN: begin
                  w_in    = code_now;
                  kwk_in  = 1'b0;
                  code_in = code_now;
               end
               glzw_pkg::CLS_KWK: begin
                  w_in     = prev_ff;
                  kwk_in   = 1'b1;
                  count_in = NF_W'(1);
                  code_in  = code_now;
               end
               glzw_pkg::CLS_BAD: status_in = glzw_pkg::ST_BAD_CODE;
               default: ;
            endcase
         end
         glzw_pkg::OP_PUSH_LIT, glzw_pkg::OP_WALK_PUSH: begin
            first_in = push_val;
            if (!stack_full) begin
               stk_we   = 1'b1;
               count_in = count_ff + NF_W'(1);
            end
            if (cmd.op == glzw_pkg::OP_WALK_PUSH) begin
               w_in = prefix_rd;
            end
         end
         glzw_pkg::OP_ADD: begin
            // The unknown-code case repeats the string's first character at the bottom.
            if (kwk_ff) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = first_ff;
            end
            if (prev_valid_ff && !nf_ff[NF_W-1]) begin
               tbl_we = 1'b1;
               nf_in  = nf_inc;
               if (nf_inc == cw_limit && cw_ff < CW_W'(MAX_CODE_BITS)) begin
                  cw_in = cw_ff + CW_W'(1);
               end
            end
            prev_in       = kwk_ff ? CODE_W'(nf_in - NF_W'(1)) : code_ff;
            prev_valid_in = 1'b1;
         end
         glzw_pkg::OP_POP_RD: begin
            count_in = count_ff - NF_W'(1);
         end
         glzw_pkg::OP_POP_DATA: begin
            pend_valid_in = 1'b1;
            pend_index_in = stk_rd;
            pend_row_in   = row_ff;
            pend_col_in   = col_ff;
            if (!col_wrap) begin
               col_in = col_next[15:0];
            end else begin
               col_in  = '0;
               row_in  = row_next[15:0];
               pass_in = pass_next;
               if (!(row_next < {1'b0, run_height_ff})) begin
                  status_in = glzw_pkg::ST_COMPLETE;
                  count_in  = '0;
               end
            end
         end
         glzw_pkg::OP_EMIT: begin
            status_in    = status_fin;
            rsp_valid_in = 1'b1;
            o_pvalid_in  = pend_valid_ff;
            o_index_in   = pend_index_ff;
            o_row_in     = pend_row_ff;
            o_col_in     = pend_col_ff;
            o_need_in    = (status_fin == glzw_pkg::ST_RUNNING) && (count_ff == '0) && bits_short;
            o_rej_in     = pend_rej_ff;
            o_done_in    = (status_fin != glzw_pkg::ST_RUNNING);
            o_status_in  = status_fin;
            o_clamped_in = clamped_ff;
         end
         glzw_pkg::OP_NOP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_min_ff    <= 4'(glzw_pkg::MIN_SIZE_HI);
         cfg_width_ff  <= 16'd1;
         cfg_height_ff <= 16'd1;
         cfg_inter_ff  <= 1'b0;
         run_min_ff    <= 4'(glzw_pkg::MIN_SIZE_HI);
         clamped_ff    <= 1'b0;
         run_width_ff  <= 16'd1;
         run_height_ff <= 16'd1;
         run_inter_ff  <= 1'b0;
         count_ff      <= '0;
         nf_ff         <= (NF_W'(1) << glzw_pkg::MIN_SIZE_HI) + NF_W'(2);
         cw_ff         <= CW_W'(glzw_pkg::MIN_SIZE_HI + 1);
         prev_valid_ff <= 1'b0;
         buf_ff        <= '0;
         cnt_ff        <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         pass_ff       <= '0;
         status_ff     <= glzw_pkg::ST_RUNNING;
         ended_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_min_ff    <= cfg_min_in;
         cfg_width_ff  <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
         cfg_inter_ff  <= cfg_inter_in;
         run_min_ff    <= run_min_in;
         clamped_ff    <= clamped_in;
         run_width_ff  <= run_width_in;
         run_height_ff <= run_height_in;
         run_inter_ff  <= run_inter_in;
         count_ff      <= count_in;
         nf_ff         <= nf_in;
         cw_ff         <= cw_in;
         prev_valid_ff <= prev_valid_in;
         buf_ff        <= buf_in;
         cnt_ff        <= cnt_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         pass_ff       <= pass_in;
         status_ff     <= status_in;
         ended_ff      <= ended_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff       <= prev_in;
      w_ff          <= w_in;
      kwk_ff        <= kwk_in;
      first_ff      <= first_in;
      code_ff       <= code_in;
      cmd_ff        <= cmd_in;
      byte_ff       <= byte_in;
      pend_valid_ff <= pend_valid_in;
      pend_index_ff <= pend_index_in;
      pend_row_ff   <= pend_row_in;
      pend_col_ff   <= pend_col_in;
      pend_rej_ff   <= pend_rej_in;
      o_pvalid_ff   <= o_pvalid_in;
      o_index_ff    <= o_index_in;
      o_row_ff      <= o_row_in;
      o_col_ff      <= o_col_in;
      o_need_ff     <= o_need_in;
      o_rej_ff      <= o_rej_in;
      o_done_ff     <= o_done_in;
      o_status_ff   <= o_status_in;
      o_clamped_ff  <= o_clamped_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_valid   = o_pvalid_ff;
   assign rsp_pixel_index   = o_index_ff;
   assign rsp_pixel_row     = o_row_ff;
   assign rsp_pixel_column  = o_col_ff;
   assign rsp_need_byte     = o_need_ff;
   assign rsp_byte_rejected = o_rej_ff;
   assign rsp_frame_done    = o_done_ff;
   assign rsp_frame_status  = o_status_ff;
   assign rsp_size_clamped  = o_clamped_ff;

endmodule

/* design/glzw_ctrl.sv */
// Controller state machine of the GIF LZW decoder.
// Depends on glzw_pkg; drives the datapath through dp_cmd_type and reads dp_status_type.
module glzw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_command,
   output logic                    req_ready,
   input  glzw_pkg::dp_status_type status,
   output glzw_pkg::dp_cmd_type    cmd
);

   glzw_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         glzw_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = (req_command == glzw_pkg::CMD_PULL) ? glzw_pkg::S_DEC : glzw_pkg::S_CMD;
            end
         end
         glzw_pkg::S_CMD: state_in = glzw_pkg::S_EMIT;
         glzw_pkg::S_DEC: begin
            if (!status.dec_go) begin
               state_in = glzw_pkg::S_POP;
            end else begin
               unique case (status.code_class)
                  glzw_pkg::CLS_CLEAR: state_in = glzw_pkg::S_DEC;
                  glzw_pkg::CLS_KNOWN, glzw_pkg::CLS_KWK: state_in = glzw_pkg::S_WALK;
                  glzw_pkg::CLS_EOI, glzw_pkg::CLS_BAD: state_in = glzw_pkg::S_POP;
                  default: state_in = glzw_pkg::S_POP;
               endcase
            end
         end
         glzw_pkg::S_WALK: begin
            state_in = status.w_literal ? glzw_pkg::S_ADD : glzw_pkg::S_WALK_DATA;
         end
         glzw_pkg::S_WALK_DATA: state_in = glzw_pkg::S_WALK;
         glzw_pkg::S_ADD: state_in = glzw_pkg::S_POP;
         glzw_pkg::S_POP: begin
            state_in = status.pop_ok ? glzw_pkg::S_POP_DATA : glzw_pkg::S_EMIT;
         end
         glzw_pkg::S_POP_DATA: state_in = glzw_pkg::S_EMIT;
         glzw_pkg::S_EMIT: begin
            if (status.slot_free) begin
               state_in = glzw_pkg::S_IDLE;
            end
         end
         default: state_in = glzw_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = glzw_pkg::OP_NOP;
      req_ready = 1'b0;
      unique case (state_ff)
         glzw_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = glzw_pkg::OP_ACCEPT;
            end
         end
         glzw_pkg::S_CMD: cmd.op = glzw_pkg::OP_SIMPLE;
         glzw_pkg::S_DEC: begin
            if (status.dec_go) begin
               cmd.op = glzw_pkg::OP_DECODE;
            end
         end
         glzw_pkg::S_WALK: begin
            if (status.w_literal) begin
               cmd.op = glzw_pkg::OP_PUSH_LIT;
            end
         end
         glzw_pkg::S_WALK_DATA: cmd.op = glzw_pkg::OP_WALK_PUSH;
         glzw_pkg::S_ADD: cmd.op = glzw_pkg::OP_ADD;
         glzw_pkg::S_POP: begin
            if (status.pop_ok) begin
               cmd.op = glzw_pkg::OP_POP_RD;
            end
         end
         glzw_pkg::S_POP_DATA: cmd.op = glzw_pkg::OP_POP_DATA;
         glzw_pkg::S_EMIT: begin
            if (status.slot_free) begin
               cmd.op = glzw_pkg::OP_EMIT;
            end
         end
         default: cmd.op = glzw_pkg::OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= glzw_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/gif_lzw_decoder_top.sv */
// Top level of the GIF LZW decoder: controller plus datapath.
// Depends on glzw_pkg, glzw_ctrl, glzw_datapath (which holds the glzw_ram instances).
//
//   Channel   Handshake                   Payload
//   request   req_valid / req_ready       req_command, req_data_byte
//   response  rsp_valid / rsp_ready       rsp_pixel_* , rsp_need_byte, rsp_byte_rejected,
//                                         rsp_frame_done, rsp_frame_status, rsp_size_clamped
//   csr       csr_write_enable            csr_index, csr_write_data
//
// Start, push and end-of-data requests pass through accept, execute and respond steps.
// A pull that pops an already stacked pixel passes through accept, decode check, pop read,
// pop data and respond. A decoding pull adds a decode step per code read, a walk step
// per string character, a read step per character from the prefix and suffix tables
// (registered read port) and a table update step. Each request gives exactly one response.
// Reset is synchronous and restores the default registers and a fresh frame; the
// tables need no clearing pass. The block accepts a new request while the previous
// response still waits in the output register, and stalls in the respond step only
// if that register is still occupied.
module gif_lzw_decoder_top #(
   parameter int MAX_CODE_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pixel_valid,
   output logic [7:0]  rsp_pixel_index,
   output logic [15:0] rsp_pixel_row,
   output logic [15:0] rsp_pixel_column,
   output logic        rsp_need_byte,
   output logic        rsp_byte_rejected,
   output logic        rsp_frame_done,
   output logic [2:0]  rsp_frame_status,
   output logic        rsp_size_clamped
);

   // The controller sequences each request; the datapath holds all frame state.
   glzw_pkg::dp_cmd_type    dp_cmd;
   glzw_pkg::dp_status_type dp_status;

   glzw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (dp_status),
      .cmd         (dp_cmd)
   );

   glzw_datapath #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_command       (req_command),
      .req_data_byte     (req_data_byte),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_pixel_valid   (rsp_pixel_valid),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_pixel_row     (rsp_pixel_row),
      .rsp_pixel_column  (rsp_pixel_column),
      .rsp_need_byte     (rsp_need_byte),
      .rsp_byte_rejected (rsp_byte_rejected),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_size_clamped  (rsp_size_clamped),
      .cmd               (dp_cmd),
      .status            (dp_status)
   );

endmodule
